@@ rtl/lbbc_pkg.sv @@
// ----------------------------------------------------------------------------
// lbbc_pkg
// Shared types and constants for the LRU byte-budget texture cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lbbc_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned LIVE_W  = 7;
  localparam int unsigned BYTES_W = 30;
  localparam int unsigned RES_W   = 35;
  localparam int unsigned BUD_W   = 34;
  localparam int unsigned STAMP_W = 64;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_SWEEP  = 2'd1;
  localparam logic [1:0] OP_ALL    = 2'd2;

  localparam logic [2:0] KIND_EVICT    = 3'd0;
  localparam logic [2:0] KIND_HIT      = 3'd1;
  localparam logic [2:0] KIND_UPLOAD   = 3'd2;
  localparam logic [2:0] KIND_OVERSIZE = 3'd3;
  localparam logic [2:0] KIND_NOROOM   = 3'd4;
  localparam logic [2:0] KIND_FAILED   = 3'd5;
  localparam logic [2:0] KIND_DONE     = 3'd6;

  typedef enum logic [2:0] {
    ACT_HIT,
    ACT_OVERSIZE,
    ACT_EVICT_VIC,
    ACT_EVICT_IDX,
    ACT_NOROOM,
    ACT_STORE,
    ACT_DONE
  } act_e;

  typedef struct packed {
    logic             latch;
    logic             miss;
    logic             vic_clr;
    logic             vic_upd;
    logic             emit;
    act_e             act;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic       hit;
    logic       sweep_hit;
    logic       oversize;
    logic       fits;
    logic       has_free;
    logic       found;
    logic       out_free;
    logic [1:0] op;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/lbbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lbbc_ctrl
// Sequencer: issues datapath commands; scans one entry per cycle, or stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module lbbc_ctrl import lbbc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t stat_i,
  output cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_HIT, S_MISS, S_FIT, S_VIC, S_EVICT, S_STORE, S_SWEEP, S_SDONE, S_STAT
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             idx_last;

  assign idx_last   = (idx_q == IDX_W'(ENTRIES - 1));
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cmd_o         = '0;
    cmd_o.act     = ACT_DONE;
    cmd_o.idx     = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          idx_d       = '0;
          // op is sampled from the port via stat during this cycle
          unique case (stat_i.op)
            OP_LOOKUP:        state_d = S_HIT;
            OP_SWEEP, OP_ALL: state_d = S_SWEEP;
            default:          state_d = S_STAT;
          endcase
        end
      end
      S_HIT: begin
        if (stat_i.hit) begin
          if (stat_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.act  = ACT_HIT;
            state_d    = S_IDLE;
          end
        end else if (idx_last) begin
          state_d = S_MISS;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_MISS: begin
        if (stat_i.oversize) begin
          if (stat_i.out_free) begin
            cmd_o.miss = 1'b1;
            cmd_o.emit = 1'b1;
            cmd_o.act  = ACT_OVERSIZE;
            state_d    = S_IDLE;
          end
        end else begin
          cmd_o.miss = 1'b1;
          state_d    = S_FIT;
        end
      end
      S_FIT: begin
        if (stat_i.has_free && stat_i.fits) begin
          state_d = S_STORE;
        end else begin
          cmd_o.vic_clr = 1'b1;
          idx_d         = '0;
          state_d       = S_VIC;
        end
      end
      S_VIC: begin
        cmd_o.vic_upd = 1'b1;
        if (idx_last) state_d = S_EVICT;
        else          idx_d   = idx_q + 1'b1;
      end
      S_EVICT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.act  = stat_i.found ? ACT_EVICT_VIC : ACT_NOROOM;
          state_d    = stat_i.found ? S_FIT : S_IDLE;
        end
      end
      S_STORE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.act  = ACT_STORE;
          state_d    = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (!stat_i.sweep_hit || stat_i.out_free) begin
          if (stat_i.sweep_hit) begin
            cmd_o.emit = 1'b1;
            cmd_o.act  = ACT_EVICT_IDX;
          end
          if (idx_last) state_d = S_SDONE;
          else          idx_d   = idx_q + 1'b1;
        end
      end
      S_SDONE, S_STAT: begin
        if (stat_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.act     = ACT_DONE;
          // op 3 raises vic_clr so the datapath leaves the sweep mark alone
          cmd_o.vic_clr = (state_q == S_STAT);
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lbbc_dp.sv @@
// ----------------------------------------------------------------------------
// lbbc_dp
// Entry store, totals, counters, victim tracking and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbbc_dp import lbbc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  output status_t                 stat_o,
  input  wire logic               cfg_valid_i,
  input  wire logic [BUD_W-1:0]   cfg_byte_budget_i,
  input  wire logic [1:0]         op_i,
  input  wire logic [31:0]        key_i,
  input  wire logic [13:0]        tex_width_i,
  input  wire logic [13:0]        tex_height_i,
  input  wire logic               is_pal4_i,
  input  wire logic [15:0]        load_id_i,
  input  wire logic               load_failed_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [2:0]              kind_o,
  output logic [15:0]             tex_id_o,
  output logic [5:0]              slot_o,
  output logic [RES_W-1:0]        resident_bytes_o,
  output logic [LIVE_W-1:0]       live_entries_o,
  output logic [31:0]             hit_count_o,
  output logic [31:0]             miss_count_o,
  output logic [31:0]             eviction_count_o,
  output logic [31:0]             upload_count_o,
  output logic [31:0]             oversized_count_o,
  output logic                    last_o
);

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [31:0]        ekey_q   [ENTRIES];
  logic [15:0]        eid_q    [ENTRIES];
  logic [BYTES_W-1:0] ebytes_q [ENTRIES];
  logic [STAMP_W-1:0] estamp_q [ENTRIES];

  logic [STAMP_W-1:0] clock_q, clock_d, mark_q, mark_d;
  logic [RES_W-1:0]   res_q, res_d;
  logic [LIVE_W-1:0]  live_q, live_d;
  logic [31:0]        hits_q, hits_d, miss_q, miss_d, evc_q, evc_d, up_q, up_d, ovs_q, ovs_d;
  logic [BUD_W-1:0]   budget_q;

  logic [1:0]         op_q;
  logic [31:0]        key_q;
  logic               pal4_q, fail_q;
  logic [15:0]        lid_q;
  logic [27:0]        texels_q;
  logic [BYTES_W-1:0] bytes_w;

  logic [STAMP_W-1:0] best_q;
  logic [IDX_W-1:0]   vic_q;
  logic [15:0]        vic_id_q;
  logic [BYTES_W-1:0] vic_bytes_q;
  logic               found_q;

  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   eslot;
  logic [15:0]        eid;
  logic [BYTES_W-1:0] ebytes;
  logic               do_write, do_stamp;

  logic [2:0]         okind;
  logic [15:0]        oid;
  logic [5:0]         oslot;
  logic               olast;

  assign bytes_w = pal4_q ? BYTES_W'(texels_q >> 1) : {texels_q, 2'b00};

  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = IDX_W'(i);
    end
  end

  always_comb begin
    stat_o.hit       = valid_q[cmd_i.idx] && (ekey_q[cmd_i.idx] == key_q);
    stat_o.sweep_hit = valid_q[cmd_i.idx] &&
                       ((op_q == OP_ALL) || (estamp_q[cmd_i.idx] <= mark_q));
    stat_o.oversize  = (budget_q != '0) && ({4'b0, bytes_w} > budget_q);
    stat_o.fits      = (budget_q == '0) ||
                       (({1'b0, res_q} + {6'b0, bytes_w}) <= {2'b0, budget_q});
    stat_o.has_free  = ~&valid_q;
    stat_o.found     = found_q;
    stat_o.out_free  = !out_valid_o || out_ready_i;
    stat_o.op        = cmd_i.latch ? op_i : op_q;
  end

  always_comb begin
    valid_d  = valid_q;
    clock_d  = clock_q;
    mark_d   = mark_q;
    res_d    = res_q;
    live_d   = live_q;
    hits_d   = hits_q;
    miss_d   = cmd_i.miss ? miss_q + 32'd1 : miss_q;
    evc_d    = evc_q;
    up_d     = up_q;
    ovs_d    = ovs_q;
    do_write = 1'b0;
    do_stamp = 1'b0;
    eslot    = (cmd_i.act == ACT_EVICT_VIC) ? vic_q : cmd_i.idx;
    eid      = (cmd_i.act == ACT_EVICT_VIC) ? vic_id_q : eid_q[cmd_i.idx];
    ebytes   = (cmd_i.act == ACT_EVICT_VIC) ? vic_bytes_q : ebytes_q[cmd_i.idx];
    okind    = KIND_DONE;
    oid      = '0;
    oslot    = '0;
    olast    = 1'b1;
    if (cmd_i.emit) begin
      unique case (cmd_i.act)
        ACT_HIT: begin
          hits_d   = hits_q + 32'd1;
          clock_d  = clock_q + 1'b1;
          do_stamp = 1'b1;
          okind    = KIND_HIT;
          oid      = eid_q[cmd_i.idx];
          oslot    = 6'(cmd_i.idx);
        end
        ACT_OVERSIZE: begin
          ovs_d = ovs_q + 32'd1;
          okind = KIND_OVERSIZE;
        end
        ACT_EVICT_VIC, ACT_EVICT_IDX: begin
          valid_d[eslot] = 1'b0;
          res_d  = res_q - {5'b0, ebytes};
          live_d = live_q - 1'b1;
          evc_d  = evc_q + 32'd1;
          okind  = KIND_EVICT;
          oid    = eid;
          oslot  = 6'(eslot);
          olast  = 1'b0;
        end
        ACT_NOROOM: okind = KIND_NOROOM;
        ACT_STORE: begin
          oslot = 6'(free_idx);
          if (fail_q) begin
            okind = KIND_FAILED;
          end else begin
            do_write          = 1'b1;
            valid_d[free_idx] = 1'b1;
            clock_d           = clock_q + 1'b1;
            res_d             = res_q + {5'b0, bytes_w};
            live_d            = live_q + 1'b1;
            up_d              = up_q + 32'd1;
            okind             = KIND_UPLOAD;
            oid               = lid_q;
          end
        end
        ACT_DONE: begin
          // sweep/evict-all move the mark; an unknown op leaves it
          if (!cmd_i.vic_clr) mark_d = clock_q;
        end
        default: okind = KIND_DONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      clock_q     <= '0;
      mark_q      <= '0;
      res_q       <= '0;
      live_q      <= '0;
      hits_q      <= '0;
      miss_q      <= '0;
      evc_q       <= '0;
      up_q        <= '0;
      ovs_q       <= '0;
      budget_q    <= '0;
      out_valid_o <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      valid_q <= valid_d;
      clock_q <= clock_d;
      mark_q  <= mark_d;
      res_q   <= res_d;
      live_q  <= live_d;
      hits_q  <= hits_d;
      miss_q  <= miss_d;
      evc_q   <= evc_d;
      up_q    <= up_d;
      ovs_q   <= ovs_d;
      if (cfg_valid_i) budget_q <= cfg_byte_budget_i;
      if (cmd_i.emit)       out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
      if (cmd_i.vic_clr)    found_q <= 1'b0;
      else if (cmd_i.vic_upd && valid_q[cmd_i.idx] && (estamp_q[cmd_i.idx] < best_q))
        found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q     <= op_i;
      key_q    <= key_i;
      pal4_q   <= is_pal4_i;
      fail_q   <= load_failed_i;
      lid_q    <= load_id_i;
      texels_q <= tex_width_i * tex_height_i;
    end
    if (cmd_i.vic_clr) begin
      best_q <= '1;
    end else if (cmd_i.vic_upd && valid_q[cmd_i.idx] && (estamp_q[cmd_i.idx] < best_q)) begin
      best_q      <= estamp_q[cmd_i.idx];
      vic_q       <= cmd_i.idx;
      vic_id_q    <= eid_q[cmd_i.idx];
      vic_bytes_q <= ebytes_q[cmd_i.idx];
    end
    if (do_stamp) estamp_q[cmd_i.idx] <= clock_d;
    if (do_write) begin
      ekey_q[free_idx]   <= key_q;
      eid_q[free_idx]    <= lid_q;
      ebytes_q[free_idx] <= bytes_w;
      estamp_q[free_idx] <= clock_d;
    end
    if (cmd_i.emit) begin
      kind_o            <= okind;
      tex_id_o          <= oid;
      slot_o            <= oslot;
      resident_bytes_o  <= res_d;
      live_entries_o    <= live_d;
      hit_count_o       <= hits_d;
      miss_count_o      <= miss_d;
      eviction_count_o  <= evc_d;
      upload_count_o    <= up_d;
      oversized_count_o <= ovs_d;
      last_o            <= olast;
    end
  end

`ifndef SYNTHESIS
  a_live_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(live_q)) else $error("live count drift");
  a_evict_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && (cmd_i.act == ACT_EVICT_VIC || cmd_i.act == ACT_EVICT_IDX)
    |-> valid_q[eslot]) else $error("evicting empty slot");
  a_store_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && cmd_i.act == ACT_STORE |-> !valid_q[free_idx])
    else $error("store without free slot");
`endif

endmodule

`default_nettype wire

@@ rtl/lru_byte_budget_cache_top.sv @@
// ----------------------------------------------------------------------------
// lru_byte_budget_cache_top
// Fully associative LRU texture cache with a resident byte budget.
// ----------------------------------------------------------------------------
// Flow from the accepting edge to a registered result: a hit scans keys, one entry per
// cycle, up to its slot; a miss scans every entry, then checks size, fit and stores, with
// a fit check, victim scan and evict step per eviction (an oversized miss stops at size).
// Sweep / evict-all scan every entry, op 3 only emits; a stalled result adds its wait.
// One item in flight; in_ready_o rises at the edge that registers the final result.
// Reset (rst_ni low, async): entries invalid, totals, clocks, counters, budget 0.
`default_nettype none

module lru_byte_budget_cache_top import lbbc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // config write channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [BUD_W-1:0]   cfg_byte_budget_i,
  // request channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         op_i,
  input  wire logic [31:0]        key_i,
  input  wire logic [13:0]        tex_width_i,
  input  wire logic [13:0]        tex_height_i,
  input  wire logic               is_pal4_i,
  input  wire logic [15:0]        load_id_i,
  input  wire logic               load_failed_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [2:0]              kind_o,
  output logic [15:0]             tex_id_o,
  output logic [5:0]              slot_o,
  output logic [RES_W-1:0]        resident_bytes_o,
  output logic [LIVE_W-1:0]       live_entries_o,
  output logic [31:0]             hit_count_o,
  output logic [31:0]             miss_count_o,
  output logic [31:0]             eviction_count_o,
  output logic [31:0]             upload_count_o,
  output logic [31:0]             oversized_count_o,
  output logic                    last_o
);

  cmd_t    cmd;
  status_t stat;

  // budget register takes a transfer on any cycle
  assign cfg_ready_o = 1'b1;

  lbbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lbbc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_byte_budget_i (cfg_byte_budget_i),
    .op_i              (op_i),
    .key_i             (key_i),
    .tex_width_i       (tex_width_i),
    .tex_height_i      (tex_height_i),
    .is_pal4_i         (is_pal4_i),
    .load_id_i         (load_id_i),
    .load_failed_i     (load_failed_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .tex_id_o          (tex_id_o),
    .slot_o            (slot_o),
    .resident_bytes_o  (resident_bytes_o),
    .live_entries_o    (live_entries_o),
    .hit_count_o       (hit_count_o),
    .miss_count_o      (miss_count_o),
    .eviction_count_o  (eviction_count_o),
    .upload_count_o    (upload_count_o),
    .oversized_count_o (oversized_count_o),
    .last_o            (last_o)
  );

endmodule

`default_nettype wire
